// File: src/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int CFG_W  = 13;
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 2;
    localparam int STS_W  = 2;

    typedef logic [REQ_W-1:0] req_t;
    typedef logic [STS_W-1:0] sts_code_t;

    localparam req_t REQ_ALLOC   = 2'd0;
    localparam req_t REQ_FREE    = 2'd1;
    localparam req_t REQ_REBUILD = 2'd2;

    localparam sts_code_t STS_ALLOC = 2'd0;
    localparam sts_code_t STS_EMPTY = 2'd1;
    localparam sts_code_t STS_DONE  = 2'd2;
    localparam sts_code_t STS_FULL  = 2'd3;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_ready;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: src/page_frame_free_list_allocator_unit.sv
// Channel  | Dir | Signals                      | Contents
// s        | in  | s_tvalid s_tready s_tdata    | request: tuser req_type, tdata page_address
// m        | out | m_tvalid m_tready m_tdata    | result: tdata alloc_address, tuser status
// cfg      | in  | cfg_we cfg_index cfg_data    | 0 total_pages, 1 reserved_pages
//
// A request is captured in S_IDLE, which also reads the ring memory head, and is
// committed in S_EXEC (the ring read data is registered).
// With a MAX_PAGES that is not a power of two, a free first reduces the page index
// by reciprocal multiplication: quotient estimate, remainder, correcting subtract.
// Reset leaves the free list built: every page from reserved_pages up is free.
// A held result does not block the next request; only its commit waits.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_free_list_allocator_unit #(
    parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire [pfa_pkg::CFG_W-1:0]     cfg_data,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [pfa_pkg::ADDR_W-1:0]    s_tdata,   // [31:0] page_address
    input  wire [pfa_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [pfa_pkg::ADDR_W-1:0]   m_tdata,   // [31:0] alloc_address
    output logic [pfa_pkg::STS_W-1:0]    m_tuser    // [1:0] status
);
    import pfa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pfa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (s_tuser),
        .page_address  (s_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .alloc_address (m_tdata),
        .status        (m_tuser)
    );

endmodule

`default_nettype wire

// File: src/pfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    output pfa_pkg::dp_cmd_t  cmd,
    input  pfa_pkg::dp_sts_t  sts
);
    import pfa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.idx_ready && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.commit = sts.idx_ready && out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pfa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_dp #(
    parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire [pfa_pkg::CFG_W-1:0]     cfg_data,
    input  wire [pfa_pkg::REQ_W-1:0]     req_type,
    input  wire [pfa_pkg::ADDR_W-1:0]    page_address,
    input  pfa_pkg::dp_cmd_t             cmd,
    output pfa_pkg::dp_sts_t             sts,
    output logic [pfa_pkg::ADDR_W-1:0]   alloc_address,
    output logic [pfa_pkg::STS_W-1:0]    status
);
    import pfa_pkg::*;

    localparam int   IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int   CNT_W = $clog2(MAX_PAGES + 1);
    localparam int   SH_W  = ADDR_W - PAGE_SHIFT;
    localparam bit   POW2  = ((MAX_PAGES & (MAX_PAGES - 1)) == 0);

    logic [CFG_W-1:0]  total_reg;
    logic [CFG_W-1:0]  reserved_reg;
    logic [CFG_W-1:0]  fresh_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    req_t              req_reg;
    logic [ADDR_W-1:0] alloc_address_reg;
    sts_code_t         status_reg;

    logic [IDX_W-1:0]  ring_mem [MAX_PAGES];
    logic [IDX_W-1:0]  rd_reg;

    logic [ADDR_W-1:0] addr_shift;
    logic [IDX_W-1:0]  free_idx;
    logic              idx_done;

    logic [CFG_W-1:0]  in_use;
    logic              have_fresh;
    logic              ring_empty;
    logic              ring_full;
    logic [IDX_W-1:0]  head_adv;
    logic [IDX_W-1:0]  tail_adv;
    logic [ADDR_W-1:0] idx_wide;
    logic [ADDR_W-1:0] alloc_next;
    sts_code_t         status_next;
    logic              mem_we;

    assign addr_shift = page_address >> PAGE_SHIFT;

    generate
        if (POW2)
        begin : g_mask
            logic [IDX_W-1:0] idx_reg;

            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    idx_reg <= addr_shift[IDX_W-1:0];
                end
            end

            assign free_idx = idx_reg;
            assign idx_done = 1'b1;
        end
        else
        begin : g_recip
            localparam logic [SH_W-1:0] RECIP = SH_W'((64'd1 << SH_W) / MAX_PAGES);

            logic [SH_W-1:0]   val_reg;
            logic [SH_W-1:0]   q_reg;
            logic [IDX_W:0]    rem_reg;
            logic [1:0]        cnt_reg;
            logic [2*SH_W-1:0] prod;
            logic [SH_W-1:0]   qm;
            logic [SH_W-1:0]   diff;
            logic [IDX_W:0]    rem_fix;

            // quotient estimate is low by at most one, so one subtract finishes
            assign prod    = (2*SH_W)'(val_reg) * (2*SH_W)'(RECIP);
            assign qm      = q_reg * SH_W'(MAX_PAGES);
            assign diff    = val_reg - qm;
            assign rem_fix = (rem_reg >= (IDX_W+1)'(MAX_PAGES))
                             ? rem_reg - (IDX_W+1)'(MAX_PAGES) : rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (cmd.load)
                begin
                    cnt_reg <= 2'd3;
                end
                else if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    val_reg <= addr_shift[SH_W-1:0];
                end
                else if (cnt_reg == 2'd3)
                begin
                    q_reg <= prod[2*SH_W-1:SH_W];
                end
                else if (cnt_reg == 2'd2)
                begin
                    rem_reg <= (IDX_W+1)'(diff);
                end
                else if (cnt_reg == 2'd1)
                begin
                    rem_reg <= rem_fix;
                end
            end

            assign free_idx = rem_reg[IDX_W-1:0];
            assign idx_done = (cnt_reg == '0) || (req_reg != REQ_FREE);
        end
    endgenerate

    assign sts.idx_ready = idx_done;

    assign in_use     = ({{(32-CFG_W){1'b0}}, total_reg} < 32'(MAX_PAGES))
                        ? total_reg : CFG_W'(MAX_PAGES);
    assign have_fresh = fresh_reg < in_use;
    assign ring_empty = (count_reg == '0);
    assign ring_full  = (count_reg == CNT_W'(MAX_PAGES));
    assign head_adv   = (head_reg == IDX_W'(MAX_PAGES - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv   = (tail_reg == IDX_W'(MAX_PAGES - 1)) ? '0 : tail_reg + 1'b1;
    assign idx_wide   = have_fresh ? ADDR_W'(fresh_reg) : ADDR_W'(rd_reg);

    always_comb
    begin
        alloc_next  = '0;
        status_next = STS_DONE;
        mem_we      = 1'b0;
        unique case (req_reg)
            REQ_ALLOC:
            begin
                if (have_fresh || !ring_empty)
                begin
                    alloc_next  = idx_wide << PAGE_SHIFT;
                    status_next = STS_ALLOC;
                end
                else
                begin
                    status_next = STS_EMPTY;
                end
            end
            REQ_FREE:
            begin
                if (ring_full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    mem_we = cmd.commit;
                end
            end
            default:
            begin
                status_next = STS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[tail_reg] <= free_idx;
        end
        rd_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= CFG_W'(4096);
            reserved_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL:    total_reg    <= cfg_data;
                CFG_RESERVED: reserved_reg <= cfg_data;
                default:      total_reg    <= total_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (req_reg)
                REQ_ALLOC:
                begin
                    if (have_fresh)
                    begin
                        fresh_reg <= fresh_reg + 1'b1;
                    end
                    else if (!ring_empty)
                    begin
                        head_reg  <= head_adv;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                REQ_FREE:
                begin
                    if (!ring_full)
                    begin
                        tail_reg  <= tail_adv;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                REQ_REBUILD:
                begin
                    fresh_reg <= reserved_reg;
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                end
                default:
                begin
                    fresh_reg <= fresh_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
        end
        if (cmd.commit)
        begin
            alloc_address_reg <= alloc_next;
            status_reg        <= status_next;
        end
    end

    assign alloc_address = alloc_address_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

// File: src/pfa_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_chk #(
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [pfa_pkg::ADDR_W-1:0]    m_tdata,
    input wire [pfa_pkg::STS_W-1:0]     m_tuser
);
    import pfa_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while one is in flight");

    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STS_ALLOC |-> m_tdata == '0)
        else $error("nonzero address without allocation");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STS_ALLOC |-> m_tdata[PAGE_SHIFT-1:0] == '0)
        else $error("allocated address not page aligned");

endmodule

bind page_frame_free_list_allocator_unit pfa_chk #(.PAGE_SHIFT(PAGE_SHIFT)) u_pfa_chk (.*);

`default_nettype wire
